[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/gcpb_pkg.sv]
// ---------------------------------------------------------------------------
// Glyph coverage pixel blend package
// Pixel format codes and the color triple type shared by the blend modules.
// ---------------------------------------------------------------------------
package gcpb_pkg;

   // Pixel format register codes; the unused code packs as 888
   localparam logic [1:0] FMT_555 = 2'd0;
   localparam logic [1:0] FMT_565 = 2'd1;
   localparam logic [1:0] FMT_888 = 2'd2;

   // Coverage end points
   localparam logic [7:0] COV_NONE = 8'h00;
   localparam logic [7:0] COV_FULL = 8'hff;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

endpackage

[src/gcpb_unpack.sv]
// ---------------------------------------------------------------------------
// Image pixel unpack
// Splits a packed background image pixel into 8-bit channels and gives the
// pixel cut to its low 16 bits under 555 and 565, and whole under 888.
// ---------------------------------------------------------------------------
module gcpb_unpack import gcpb_pkg::*; (
   input  logic [1:0]  pixel_format,
   input  logic [31:0] image_pixel,
   output rgb_type     image_rgb,
   output logic [31:0] image_word
);

   // Shift each channel field up so its top bit lands on bit 7
   always_comb begin
      case (pixel_format)
         FMT_555: begin
            image_rgb.red   = {image_pixel[14:10], 3'b000};
            image_rgb.green = {image_pixel[9:5], 3'b000};
            image_rgb.blue  = {image_pixel[4:0], 3'b000};
            image_word      = {16'h0000, image_pixel[15:0]};
         end
         FMT_565: begin
            image_rgb.red   = {image_pixel[15:11], 3'b000};
            image_rgb.green = {image_pixel[10:5], 2'b00};
            image_rgb.blue  = {image_pixel[4:0], 3'b000};
            image_word      = {16'h0000, image_pixel[15:0]};
         end
         default: begin
            image_rgb.red   = image_pixel[23:16];
            image_rgb.green = image_pixel[15:8];
            image_rgb.blue  = image_pixel[7:0];
            image_word      = image_pixel;
         end
      endcase
   end

endmodule

[src/gcpb_blend.sv]
// ---------------------------------------------------------------------------
// Channel blend
// One channel: bg + floor((fg - bg) * coverage / 256), kept to 8 bits.
// ---------------------------------------------------------------------------
module gcpb_blend import gcpb_pkg::*; (
   input  logic [7:0] fg,
   input  logic [7:0] bg,
   input  logic [7:0] coverage,
   output logic [7:0] mixed
);

   logic signed [17:0] diff;
   logic signed [17:0] cov_ext;
   logic signed [17:0] prod;

   // Signed difference times coverage; bits 15:8 are the floored quotient
   // modulo 256, which is all the 8-bit sum needs
   assign diff    = $signed({10'd0, fg}) - $signed({10'd0, bg});
   assign cov_ext = $signed({10'd0, coverage});
   assign prod    = diff * cov_ext;
   assign mixed   = bg + prod[15:8];

endmodule

[src/gcpb_pack.sv]
// ---------------------------------------------------------------------------
// Pixel pack
// Keeps the top bits of each channel and packs red over green over blue.
// ---------------------------------------------------------------------------
module gcpb_pack import gcpb_pkg::*; (
   input  logic [1:0]  pixel_format,
   input  rgb_type     color,
   output logic [31:0] packed_word
);

   always_comb begin
      case (pixel_format)
         FMT_555: begin
            packed_word = {17'h00000, color.red[7:3], color.green[7:3], color.blue[7:3]};
         end
         FMT_565: begin
            packed_word = {16'h0000, color.red[7:3], color.green[7:2], color.blue[7:3]};
         end
         default: begin
            packed_word = {8'h00, color.red, color.green, color.blue};
         end
      endcase
   end

endmodule

[src/glyph_coverage_pixel_blend_unit.sv]
// ---------------------------------------------------------------------------
// Glyph coverage pixel blend unit
// Blends foreground over background color or image pixel by glyph coverage
// and packs the result as 555, 565 or 888.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  coverage, colors, image pixel, last
//  rsp_      out        rsp_valid/rsp_stall  pixel_value, last_out
//  csr_      in         csr_wr_en            pixel_format (2 bits)
//
//  One word per clock while the result side does not stall; a word accepted
//  passes through an input register, the blend and pack logic, then the
//  result register.
//  Reset clears both valid flags and sets pixel_format to 888.
//  A stalled result holds in the result register; the input register takes
//  one more word, and req_stall rises only when both registers are full and
//  the result is stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module glyph_coverage_pixel_blend_unit import gcpb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_coverage,
   input  logic [7:0]  req_fg_red,
   input  logic [7:0]  req_fg_green,
   input  logic [7:0]  req_fg_blue,
   input  logic [7:0]  req_bg_red,
   input  logic [7:0]  req_bg_green,
   input  logic [7:0]  req_bg_blue,
   input  logic        req_use_image,
   input  logic [31:0] req_image_pixel,
   input  logic        req_last_in_span,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_value,
   output logic        rsp_last_out
);

   logic [1:0]  pixel_format_ff;

   logic        in_valid_ff;
   logic [7:0]  coverage_ff;
   rgb_type     fg_ff;
   rgb_type     bg_ff;
   logic        use_image_ff;
   logic [31:0] image_pixel_ff;
   logic        last_ff;

   logic        out_valid_ff;
   logic [31:0] pixel_ff;
   logic        last_out_ff;

   logic        out_advance;
   logic        in_advance;

   rgb_type     image_rgb;
   logic [31:0] image_word;
   rgb_type     bg_sel;
   rgb_type     mix_rgb;
   rgb_type     color_sel;
   logic [31:0] packed_word;
   logic [31:0] pixel_in;

   // Flow control: a register moves when it is empty or its consumer takes
   assign out_advance = !out_valid_ff || !rsp_stall;
   assign in_advance  = !in_valid_ff || out_advance;
   assign req_stall   = !in_advance;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_888;
      end else if (csr_wr_en) begin
         pixel_format_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && req_valid) begin
         coverage_ff    <= req_coverage;
         fg_ff          <= '{red: req_fg_red, green: req_fg_green, blue: req_fg_blue};
         bg_ff          <= '{red: req_bg_red, green: req_bg_green, blue: req_bg_blue};
         use_image_ff   <= req_use_image;
         image_pixel_ff <= req_image_pixel;
         last_ff        <= req_last_in_span;
      end
   end

   // Unpack the background image pixel
   gcpb_unpack u_unpack (
      .pixel_format (pixel_format_ff),
      .image_pixel  (image_pixel_ff),
      .image_rgb    (image_rgb),
      .image_word   (image_word)
   );

   assign bg_sel = use_image_ff ? image_rgb : bg_ff;

   // Blend each channel
   gcpb_blend u_blend_red (
      .fg       (fg_ff.red),
      .bg       (bg_sel.red),
      .coverage (coverage_ff),
      .mixed    (mix_rgb.red)
   );

   gcpb_blend u_blend_green (
      .fg       (fg_ff.green),
      .bg       (bg_sel.green),
      .coverage (coverage_ff),
      .mixed    (mix_rgb.green)
   );

   gcpb_blend u_blend_blue (
      .fg       (fg_ff.blue),
      .bg       (bg_sel.blue),
      .coverage (coverage_ff),
      .mixed    (mix_rgb.blue)
   );

   // Pick background, foreground or blend at the coverage end points
   always_comb begin
      if (coverage_ff == COV_NONE) begin
         color_sel = bg_sel;
      end else if (coverage_ff == COV_FULL) begin
         color_sel = fg_ff;
      end else begin
         color_sel = mix_rgb;
      end
   end

   gcpb_pack u_pack (
      .pixel_format (pixel_format_ff),
      .color        (color_sel),
      .packed_word  (packed_word)
   );

   // Pass the image pixel through where nothing is drawn, cut to its low 16 bits under 555 and 565
   assign pixel_in = (coverage_ff == COV_NONE && use_image_ff) ? image_word : packed_word;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance && in_valid_ff) begin
         pixel_ff    <= pixel_in;
         last_out_ff <= last_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_value = pixel_ff;
   assign rsp_last_out    = last_out_ff;

   // Stall the input only with both registers full and the output blocked
   `ASSERT_IMPL(a_stall_when_full, clock, reset, req_stall, in_valid_ff && out_valid_ff && rsp_stall)
   // A word leaving the input register shows up as a result
   `ASSERT_NEXT(a_word_reaches_out, clock, reset, in_valid_ff && out_advance, out_valid_ff)
   // A blocked input word stays in its register
   `ASSERT_NEXT(a_blocked_word_held, clock, reset, in_valid_ff && !out_advance, in_valid_ff)

endmodule

[bench/glyph_coverage_pixel_blend_unit_test.sv]
// ---------------------------------------------------------------------------
// Glyph coverage pixel blend unit testbench
// Drives coverage/color words through the blend unit under every pixel
// format, with random idle gaps on the input and random stalls on the
// result side. A scoreboard predicts each packed pixel from the accepted
// word and the current format, and checks results in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_coverage_pixel_blend_unit_test;
   import gcpb_pkg::*;

   // Spare format code; the unit packs it as 888
   localparam logic [1:0] FMT_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int WORDS_PER_PHASE = 145;

   typedef struct {
      logic [7:0]  coverage;
      rgb_type     fg;
      rgb_type     bg;
      logic        use_image;
      logic [31:0] image_pixel;
      logic        last;
   } span_word_type;

   typedef struct {
      logic [31:0] pixel;
      logic        last;
   } packed_pixel_type;

   // Predicts packed pixels and checks the unit's results in order
   class blend_scoreboard;
      logic [1:0]       format;
      packed_pixel_type expected_pixels [$];
      int               errors;

      function new();
         format = FMT_888;
         errors = 0;
      endfunction

      function logic [7:0] unpack_field(logic [31:0] pix, int shift, int len);
         logic [31:0] field;
         field = (pix >> shift) & ((32'd1 << len) - 1);
         field = field << (8 - len);
         return field[7:0];
      endfunction

      // bg + floor((fg - bg) * cov / 256); arithmetic shift floors negatives
      function logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg, logic [7:0] cov);
         int prod;
         int total;
         prod = (int'(fg) - int'(bg)) * int'(cov);
         total = int'(bg) + (prod >>> 8);
         return total[7:0];
      endfunction

      function logic [31:0] pack_rgb(rgb_type c, int lr, int lg, int lb);
         logic [31:0] r, g, b;
         r = {24'd0, c.red};
         g = {24'd0, c.green};
         b = {24'd0, c.blue};
         r = r >> (8 - lr);
         g = g >> (8 - lg);
         b = b >> (8 - lb);
         return (r << (lg + lb)) | (g << lb) | b;
      endfunction

      function logic [31:0] blend_pixel(span_word_type w);
         int          lr, lg, lb;
         logic [31:0] pix;
         rgb_type     back;
         rgb_type     mix;
         case (format)
            FMT_555: begin
               lr = 5; lg = 5; lb = 5;
            end
            FMT_565: begin
               lr = 5; lg = 6; lb = 5;
            end
            default: begin
               lr = 8; lg = 8; lb = 8;
            end
         endcase
         // 16-bit formats only see the low half of the image pixel
         pix = w.image_pixel;
         if (lr != 8) pix[31:16] = '0;
         back = w.bg;
         if (w.use_image) begin
            back.red   = unpack_field(pix, lg + lb, lr);
            back.green = unpack_field(pix, lb, lg);
            back.blue  = unpack_field(pix, 0, lb);
         end
         if (w.coverage == COV_NONE) begin
            return w.use_image ? pix : pack_rgb(back, lr, lg, lb);
         end
         if (w.coverage == COV_FULL) return pack_rgb(w.fg, lr, lg, lb);
         mix.red   = mix_channel(w.fg.red, back.red, w.coverage);
         mix.green = mix_channel(w.fg.green, back.green, w.coverage);
         mix.blue  = mix_channel(w.fg.blue, back.blue, w.coverage);
         return pack_rgb(mix, lr, lg, lb);
      endfunction

      function void note_word(span_word_type w);
         packed_pixel_type want;
         want.pixel = blend_pixel(w);
         want.last  = w.last;
         expected_pixels.push_back(want);
      endfunction

      function void check_word(logic [31:0] pixel, logic last);
         packed_pixel_type want;
         if (expected_pixels.size() == 0) begin
            $error("result word with nothing expected: pixel_value %h", pixel);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (pixel !== want.pixel) begin
            $error("pixel_value: expected %h, actual %h", want.pixel, pixel);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_out: expected %b, actual %b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = FMT_888;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_coverage = '0;
   logic [7:0]  req_fg_red = '0;
   logic [7:0]  req_fg_green = '0;
   logic [7:0]  req_fg_blue = '0;
   logic [7:0]  req_bg_red = '0;
   logic [7:0]  req_bg_green = '0;
   logic [7:0]  req_bg_blue = '0;
   logic        req_use_image = 1'b0;
   logic [31:0] req_image_pixel = '0;
   logic        req_last_in_span = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_value;
   logic        rsp_last_out;

   logic        steady = 1'b0;
   int          clock_cycles = 0;
   logic [1:0]  random_formats [$] = '{FMT_555, FMT_565, FMT_888, FMT_SPARE,
                                       FMT_565, FMT_555, FMT_888};

   blend_scoreboard board = new();

   glyph_coverage_pixel_blend_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coverage     (req_coverage),
      .req_fg_red       (req_fg_red),
      .req_fg_green     (req_fg_green),
      .req_fg_blue      (req_fg_blue),
      .req_bg_red       (req_bg_red),
      .req_bg_green     (req_bg_green),
      .req_bg_blue      (req_bg_blue),
      .req_use_image    (req_use_image),
      .req_image_pixel  (req_image_pixel),
      .req_last_in_span (req_last_in_span),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_last_out     (rsp_last_out)
   );

   always #2 clock = ~clock;

   // Track format writes and accepted input words
   always @(posedge clock) begin
      span_word_type w;
      if (!reset) begin
         if (csr_wr_en) board.format = csr_wr_data;
         if (req_valid && !req_stall) begin
            w.coverage    = req_coverage;
            w.fg          = {req_fg_red, req_fg_green, req_fg_blue};
            w.bg          = {req_bg_red, req_bg_green, req_bg_blue};
            w.use_image   = req_use_image;
            w.image_pixel = req_image_pixel;
            w.last        = req_last_in_span;
            board.note_word(w);
         end
      end
   end

   // Check accepted result words
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_word(rsp_pixel_value, rsp_last_out);
   end

   // Stall the result side at random, except in the steady stretch
   always @(posedge clock) begin
      rsp_stall <= steady ? 1'b0 : ($urandom_range(99) < 23);
   end

   // Bound the run
   always @(posedge clock) begin
      clock_cycles++;
      if (clock_cycles > CYCLE_LIMIT) begin
         $display("glyph_coverage_pixel_blend_unit: mismatch");
         $finish;
      end
   end

   function automatic span_word_type make_word(logic [7:0] cov, rgb_type fg, rgb_type bg,
                                               logic img, logic [31:0] pix, logic last);
      span_word_type w;
      w.coverage    = cov;
      w.fg          = fg;
      w.bg          = bg;
      w.use_image   = img;
      w.image_pixel = pix;
      w.last        = last;
      return w;
   endfunction

   function automatic span_word_type random_word();
      int         sel;
      logic [7:0] cov;
      sel = $urandom_range(9);
      if (sel < 2) cov = COV_NONE;
      else if (sel < 4) cov = COV_FULL;
      else cov = 8'($urandom_range(255));
      return make_word(cov, 24'($urandom()), 24'($urandom()), $urandom_range(99) < 40,
                       $urandom(), $urandom_range(7) == 0);
   endfunction

   // Present one word, hold it until accepted, then maybe idle a while
   task automatic send_word(span_word_type w);
      req_valid        <= 1'b1;
      req_coverage     <= w.coverage;
      req_fg_red       <= w.fg.red;
      req_fg_green     <= w.fg.green;
      req_fg_blue      <= w.fg.blue;
      req_bg_red       <= w.bg.red;
      req_bg_green     <= w.bg.green;
      req_bg_blue      <= w.bg.blue;
      req_use_image    <= w.use_image;
      req_image_pixel  <= w.image_pixel;
      req_last_in_span <= w.last;
      do @(posedge clock); while (req_stall);
      while (!steady && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Drain all results, let the pipeline settle, then write the format
   task automatic write_format(logic [1:0] fmt);
      req_valid <= 1'b0;
      while (board.expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Corner words: pass-through, full foreground, image unpack, floor of negatives
   task automatic send_corners();
      send_word(make_word(COV_NONE, 24'h123456, 24'hff00ff, 1'b0, 32'h0000_0000, 1'b1));
      send_word(make_word(COV_FULL, 24'hff0080, 24'h00ff7f, 1'b1, 32'hffff_ffff, 1'b0));
      send_word(make_word(COV_NONE, 24'h000000, 24'hffffff, 1'b1, 32'hffff_ffff, 1'b1));
      send_word(make_word(8'h80, 24'h000000, 24'hffffff, 1'b1, 32'ha5a5_5a5a, 1'b0));
      send_word(make_word(8'h01, 24'h000000, 24'hffffff, 1'b0, 32'h0000_0000, 1'b0));
      send_word(make_word(8'hfe, 24'hffffff, 24'h000000, 1'b1, 32'h5a5a_8000, 1'b1));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset format, then each written format
      send_corners();
      write_format(FMT_555);
      send_corners();
      write_format(FMT_565);
      send_corners();
      write_format(FMT_SPARE);
      send_corners();

      // Random phases; the third runs with no idling on either side
      for (int p = 0; p < random_formats.size(); p++) begin
         write_format(random_formats[p]);
         steady <= (p == 2);
         for (int i = 0; i < WORDS_PER_PHASE; i++) send_word(random_word());
      end
      steady <= 1'b0;

      // Drain and let the pipeline empty before judging
      req_valid <= 1'b0;
      while (board.expected_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("glyph_coverage_pixel_blend_unit: match");
      end else begin
         $display("glyph_coverage_pixel_blend_unit: mismatch");
      end
      $finish;
   end

endmodule
